FILE: rtl/sbpa_pkg.sv
// Shared types and constants of the segmented bump page allocator.
package sbpa_pkg;

   localparam int unsigned ADDR_W = 32;

   localparam logic [31:0] AVAILABLE_TYPE = 32'd1;

   typedef enum logic [1:0] {
      ST_PAGE    = 2'd0,
      ST_OOM     = 2'd1,
      ST_KEPT    = 2'd2,
      ST_SKIPPED = 2'd3
   } sbpa_status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic trim;
      logic add_done;
      logic alloc_give;
      logic alloc_next;
      logic oom;
   } sbpa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_empty;
      logic seg_used;
      logic out_free;
   } sbpa_stat_type;

endpackage

FILE: rtl/sbpa_ctrl.sv
// Controller state machine of the segmented bump page allocator.
module sbpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_type,
   output logic                  req_ready,
   input  sbpa_pkg::sbpa_stat_type stat,
   output sbpa_pkg::sbpa_cmd_type  cmd
);
   import sbpa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TRIM,
      S_COMMIT,
      S_READ,
      S_CHECK
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = req_type ? S_READ : S_TRIM;
            end
         end
         S_TRIM: begin
            cmd.trim = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.add_done = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_READ: begin
            if (stat.slot_empty) begin
               if (stat.out_free) begin
                  cmd.oom  = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // A used-up segment passes allocation on to the next slot upward.
            if (stat.seg_used) begin
               cmd.alloc_next = 1'b1;
               state_in       = S_READ;
            end else if (stat.out_free) begin
               cmd.alloc_give = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/sbpa_dpath.sv
// Datapath of the segmented bump page allocator: segment stores, slot pointer, result register.
module sbpa_dpath #(
   parameter int unsigned NUM_SEGMENTS = 8,
   parameter int unsigned PAGE_BYTES   = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_type,
   input  logic [sbpa_pkg::ADDR_W-1:0]   req_region_start,
   input  logic [sbpa_pkg::ADDR_W-1:0]   req_region_length,
   input  logic [31:0]                   req_region_type,
   input  sbpa_pkg::sbpa_cmd_type        cmd,
   output sbpa_pkg::sbpa_stat_type       stat,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [sbpa_pkg::ADDR_W-1:0]   rsp_page_address,
   output sbpa_pkg::sbpa_status_type     rsp_status
);
   import sbpa_pkg::*;

   localparam int unsigned SLOT_W = $clog2(NUM_SEGMENTS + 1);
   localparam int unsigned IDX_W  = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
   localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(NUM_SEGMENTS);
   // PAGE_BYTES is a power of two, so the page offset is a mask.
   localparam logic [ADDR_W-1:0] PAGE_W   = ADDR_W'(PAGE_BYTES);
   localparam logic [ADDR_W-1:0] OFF_MASK = PAGE_W - 1'b1;

   logic [ADDR_W-1:0] base_mem [NUM_SEGMENTS];
   logic [ADDR_W-1:0] next_mem [NUM_SEGMENTS];

   logic              kind_ff;
   logic [ADDR_W-1:0] start_ff;
   logic [ADDR_W-1:0] length_ff;
   logic [31:0]       rtype_ff;

   logic [ADDR_W-1:0] base_ff;
   logic [ADDR_W-1:0] span_ff;
   logic              skip_ff;

   logic [SLOT_W-1:0] active_ff;
   logic [ADDR_W-1:0] rd_base_ff;
   logic [ADDR_W-1:0] rd_next_ff;

   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   sbpa_status_type   rsp_status_ff;

   logic [ADDR_W-1:0] off;
   logic [ADDR_W-1:0] gap;
   logic              unaligned;
   logic              too_small;
   logic [ADDR_W-1:0] aligned_start;
   logic [ADDR_W-1:0] remaining;
   logic [ADDR_W-1:0] trimmed;
   logic              skip_in;
   logic [SLOT_W-1:0] slot_below;
   logic [IDX_W-1:0]  act_idx;
   logic [IDX_W-1:0]  add_idx;
   logic [ADDR_W-1:0] page_new;

   // Region trimming: round the start up to a page, cut the length to whole pages.
   always_comb begin
      off           = start_ff & OFF_MASK;
      gap           = PAGE_W - off;
      unaligned     = (off != '0);
      too_small     = unaligned && (length_ff <= gap);
      aligned_start = unaligned ? ((start_ff & ~OFF_MASK) + PAGE_W) : start_ff;
      remaining     = unaligned ? (length_ff - gap) : length_ff;
      trimmed       = remaining & ~OFF_MASK;
      skip_in       = (rtype_ff != AVAILABLE_TYPE) || (active_ff == '0) || too_small ||
                      (trimmed == '0);
   end

   assign slot_below = active_ff - 1'b1;
   assign act_idx    = active_ff[IDX_W-1:0];
   assign add_idx    = slot_below[IDX_W-1:0];
   assign page_new   = rd_next_ff - PAGE_W;

   assign stat.slot_empty = (active_ff == SLOT_NONE);
   assign stat.seg_used   = (rd_next_ff == rd_base_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_type;
         start_ff  <= req_region_start;
         length_ff <= req_region_length;
         rtype_ff  <= req_region_type;
      end
      if (cmd.trim) begin
         base_ff <= aligned_start;
         span_ff <= trimmed;
         skip_ff <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_done && !skip_ff) begin
         base_mem[add_idx] <= base_ff;
         next_mem[add_idx] <= base_ff + span_ff;
      end else if (cmd.alloc_give) begin
         next_mem[act_idx] <= page_new;
      end
      if (active_ff < SLOT_NONE) begin
         rd_base_ff <= base_mem[act_idx];
         rd_next_ff <= next_mem[act_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= SLOT_NONE;
      end else if (cmd.add_done && !skip_ff) begin
         active_ff <= slot_below;
      end else if (cmd.alloc_next) begin
         active_ff <= active_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.add_done || cmd.alloc_give || cmd.oom) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_done) begin
         rsp_addr_ff   <= '0;
         rsp_status_ff <= skip_ff ? ST_SKIPPED : ST_KEPT;
      end else if (cmd.alloc_give) begin
         rsp_addr_ff   <= page_new;
         rsp_status_ff <= ST_PAGE;
      end else if (cmd.oom) begin
         rsp_addr_ff   <= '0;
         rsp_status_ff <= ST_OOM;
      end
   end

   // The request kind is kept for the whole request; the stores are read whenever a slot is active.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_address = (rsp_status_ff == ST_PAGE || !kind_ff) ? rsp_addr_ff : '0;
   assign rsp_status       = rsp_status_ff;

endmodule

FILE: rtl/segmented_bump_page_allocator.sv
// Top level of the segmented bump page allocator.
//
// Usage: the request channel (req_valid/req_ready) carries one request per
// handshake. req_type 0 offers a memory region (req_region_start, _length,
// _type); only type 1 regions are kept, trimmed to whole pages and stored in
// the next free segment slot from the top down. req_type 1 asks for one page,
// taken downward from the active segment. The result channel (rsp_valid/
// rsp_ready) returns exactly one result per request: rsp_page_address and
// rsp_status (page given, out of memory, region kept, region skipped).
// Requests are handled one at a time. A region is trimmed, then committed, and
// its result is registered before the next request is taken. A page request
// checks the active segment through a registered read of the segment store and
// passes each used-up segment on to the next slot upward before it gives a
// page or, once no slot is left, an out-of-memory result.
// The result sits in an output register, so a request may be accepted while
// an earlier result still waits; a stalled receiver holds the result and
// stops the next request at its final step. Reset empties the segment list
// and the result register; store contents are undefined until written.
// PAGE_BYTES must be a power of two.
module segmented_bump_page_allocator #(
   parameter int unsigned NUM_SEGMENTS = 8,
   parameter int unsigned PAGE_BYTES   = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [sbpa_pkg::ADDR_W-1:0] req_region_start,
   input  logic [sbpa_pkg::ADDR_W-1:0] req_region_length,
   input  logic [31:0]                 req_region_type,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sbpa_pkg::ADDR_W-1:0] rsp_page_address,
   output sbpa_pkg::sbpa_status_type   rsp_status
);
   import sbpa_pkg::*;

   sbpa_cmd_type  cmd;
   sbpa_stat_type stat;

   sbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sbpa_dpath #(
      .NUM_SEGMENTS (NUM_SEGMENTS),
      .PAGE_BYTES   (PAGE_BYTES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_region_start  (req_region_start),
      .req_region_length (req_region_length),
      .req_region_type   (req_region_type),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_page_address  (rsp_page_address),
      .rsp_status        (rsp_status)
   );

endmodule

FILE: rtl/sbpa_checker.sv
// Port-level checker of the segmented bump page allocator and its bind.
module sbpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_page_address,
   input logic [1:0]  rsp_status
);
   import sbpa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_page_address) &&
                                  $stable(rsp_status))
      else $error("result changed while stalled");

   a_region_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_KEPT || rsp_status == ST_SKIPPED ||
                    rsp_status == ST_OOM) |-> rsp_page_address == '0)
      else $error("nonzero address on a result without a page");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind segmented_bump_page_allocator sbpa_checker u_sbpa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_page_address (rsp_page_address),
   .rsp_status       (rsp_status)
);
